@@ hw/rtl/asp_pkg.sv @@
// Shared types and constants for the subscript specifier parser.
`default_nettype none

package asp_pkg;

  // Largest number of dimensions that one specifier may carry.
  localparam int MAX_DIMS = 7;

  // Width of a dimension counter that can also hold MAX_DIMS itself.
  localparam int CNT_W = $clog2(MAX_DIMS + 1);
  // Width of an address into the bound stores.
  localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  localparam int VAL_W     = 32;
  localparam int CHR_W     = 8;
  localparam int KIND_W    = 2;
  localparam int DIM_IDX_W = 4;
  localparam int DIM_CNT_W = 5;
  localparam int ERR_W     = 2;

  localparam logic [CHR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHR_W-1:0] CH_CR     = 8'h0D;

  localparam logic [KIND_W-1:0] KIND_NAME = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DIM  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUM  = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NO_CLOSE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY = 2'd2;

  typedef enum logic [1:0] {
    NUM_WAIT   = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_DONE   = 2'd2
  } num_state_e;

  typedef enum logic [3:0] {
    S_RUN   = 4'b0001,
    S_FIN   = 4'b0010,
    S_FLUSH = 4'b0100,
    S_SUM   = 4'b1000
  } ctrl_state_e;

  typedef struct packed {
    logic char_step;  // parse the character accepted this cycle
    logic finish;     // close the last field after the final character
    logic emit_dim;   // send the next stored dimension
    logic emit_sum;   // send the summary and return to the reset state
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;   // the output register can take a result this cycle
    logic flush_more;  // stored dimensions remain to be sent
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/array_subscript_spec_parser_core.sv @@
// Top level of the subscript specifier parser: controller plus datapath.
//
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  chr_i, last_i
// out      output     out_valid_o / out_ready_i kind_o, name_char_o, dim_index_o,
//                                              dim_start_o, dim_end_o, is_array_o,
//                                              is_slice_o, dim_count_o, error_o,
//                                              last_out_o
//
// A character is taken while the output register is free or being emptied in
// the same cycle; the single output register sets the input rate.
// After the final character the block closes the last field, sends each
// stored dimension if the list closed without error, sees that the flush is
// done and then sends the summary. Input is not taken during that flush.
// Reset is asynchronous and active low; it returns the parser to the name phase.
// A stalled output holds its result and back-pressures the input channel.
`default_nettype none

module array_subscript_spec_parser_core import asp_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [CHR_W-1:0]        chr_i,
  input  wire logic                    last_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [KIND_W-1:0]            kind_o,
  output logic [CHR_W-1:0]             name_char_o,
  output logic [DIM_IDX_W-1:0]         dim_index_o,
  output logic signed [VAL_W-1:0]      dim_start_o,
  output logic signed [VAL_W-1:0]      dim_end_o,
  output logic                         is_array_o,
  output logic                         is_slice_o,
  output logic [DIM_CNT_W-1:0]         dim_count_o,
  output logic [ERR_W-1:0]             error_o,
  output logic                         last_out_o
);

  // Commands flow from the controller; status flows back from the datapath.
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // The controller decides when a character is parsed, when the last field is
  // closed and when each stored dimension and the summary are sent.
  asp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // The datapath holds the field parser, the bound stores and the output
  // register that decouples the two channels.
  asp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .chr_i       (chr_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .name_char_o (name_char_o),
    .dim_index_o (dim_index_o),
    .dim_start_o (dim_start_o),
    .dim_end_o   (dim_end_o),
    .is_array_o  (is_array_o),
    .is_slice_o  (is_slice_o),
    .dim_count_o (dim_count_o),
    .error_o     (error_o),
    .last_out_o  (last_out_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/asp_ctrl.sv @@
// Sequencing state machine of the subscript specifier parser.
`default_nettype none

module asp_ctrl import asp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      last_i,
  output logic           in_ready_o,
  output ctrl_cmd_t      cmd_o,
  input  wire ctrl_sts_t sts_i
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign in_ready_o = (state_q == S_RUN) && sts_i.slot_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_RUN: begin
        cmd_o.char_step = accept;
        if (accept && last_i) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_FLUSH;
      end
      S_FLUSH: begin
        if (sts_i.flush_more) begin
          cmd_o.emit_dim = sts_i.slot_free;
        end else begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_sum = 1'b1;
          state_d        = S_RUN;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/asp_datapath.sv @@
// Field parser, bound stores and output register of the subscript specifier parser.
`default_nettype none

module asp_datapath import asp_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ctrl_cmd_t              cmd_i,
  output ctrl_sts_t                   sts_o,
  input  wire logic [CHR_W-1:0]       chr_i,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output logic [KIND_W-1:0]           kind_o,
  output logic [CHR_W-1:0]            name_char_o,
  output logic [DIM_IDX_W-1:0]        dim_index_o,
  output logic signed [VAL_W-1:0]     dim_start_o,
  output logic signed [VAL_W-1:0]     dim_end_o,
  output logic                        is_array_o,
  output logic                        is_slice_o,
  output logic [DIM_CNT_W-1:0]        dim_count_o,
  output logic [ERR_W-1:0]            error_o,
  output logic                        last_out_o
);

  // Parser state.
  logic             phase_q, phase_d;
  logic             cp_q, cp_d;
  logic [CNT_W-1:0] fc_q, fc_d;
  logic             colon_q, colon_d;
  logic             pn_q, pn_d;
  num_state_e       ns_q, ns_d;
  logic             neg_q, neg_d;
  logic [VAL_W-1:0] acc_q, acc_d;
  logic [VAL_W-1:0] first_q, first_d;
  logic             slice_q, slice_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] fl_q, fl_d;

  // Bound stores, only read at entries written during the current specifier.
  logic [VAL_W-1:0] start_mem [MAX_DIMS];
  logic [VAL_W-1:0] end_mem [MAX_DIMS];

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic [KIND_W-1:0]    kind_q, kind_d;
  logic [CHR_W-1:0]     nc_q, nc_d;
  logic [DIM_IDX_W-1:0] didx_q, didx_d;
  logic [VAL_W-1:0]     dst_q, dst_d;
  logic [VAL_W-1:0]     den_q, den_d;
  logic                 arr_q, arr_d;
  logic                 sl_q, sl_d;
  logic [DIM_CNT_W-1:0] cnt_q, cnt_d;
  logic [ERR_W-1:0]     err_q, err_d;
  logic                 lo_q, lo_d;

  logic             load;
  logic             ok;
  logic [VAL_W-1:0] val;
  logic             pn_e;
  num_state_e       ns_e;
  logic             fin_req;
  logic             fin_pn;
  logic             wr_en;
  logic [VAL_W-1:0] wr_st;
  logic [VAL_W-1:0] wr_en_val;
  logic             is_digit;
  logic             is_ws;

  assign ok                = phase_q && cp_q && !ovf_q;
  assign sts_o.slot_free   = !out_valid_q || out_ready_i;
  assign sts_o.flush_more  = ok && (fl_q < fc_q);

  assign val      = neg_q ? (VAL_W'(0) - acc_q) : acc_q;
  // A pending close parenthesis is an ordinary character once more text follows.
  assign pn_e     = pn_q | cp_q;
  assign ns_e     = cp_q ? NUM_DONE : ns_q;
  assign is_digit = (chr_i >= CH_ZERO) && (chr_i <= CH_NINE);
  assign is_ws    = (chr_i >= CH_TAB) && (chr_i <= CH_CR);

  always_comb begin
    phase_d  = phase_q;
    cp_d     = cp_q;
    fc_d     = fc_q;
    colon_d  = colon_q;
    pn_d     = pn_q;
    ns_d     = ns_q;
    neg_d    = neg_q;
    acc_d    = acc_q;
    first_d  = first_q;
    slice_d  = slice_q;
    ovf_d    = ovf_q;
    fl_d     = fl_q;
    load     = 1'b0;
    kind_d   = kind_q;
    nc_d     = nc_q;
    didx_d   = didx_q;
    dst_d    = dst_q;
    den_d    = den_q;
    arr_d    = arr_q;
    sl_d     = sl_q;
    cnt_d    = cnt_q;
    err_d    = err_q;
    lo_d     = lo_q;
    fin_req  = 1'b0;
    fin_pn   = pn_q;
    wr_en    = 1'b0;
    wr_st    = '0;
    wr_en_val = '0;

    if (cmd_i.char_step) begin
      if (!phase_q) begin
        if (chr_i == CH_LPAREN) begin
          phase_d = 1'b1;
        end else begin
          load   = 1'b1;
          kind_d = KIND_NAME;
          nc_d   = chr_i;
          didx_d = '0;
          dst_d  = '0;
          den_d  = '0;
          arr_d  = 1'b0;
          sl_d   = 1'b0;
          cnt_d  = '0;
          err_d  = ERR_NONE;
          lo_d   = 1'b0;
        end
      end else if (chr_i != CH_SPACE) begin
        pn_d = pn_e;
        ns_d = ns_e;
        cp_d = (chr_i == CH_RPAREN);
        if (chr_i != CH_RPAREN) begin
          if (chr_i == CH_COMMA) begin
            fin_req = 1'b1;
            fin_pn  = pn_e;
          end else if ((chr_i == CH_COLON) && !colon_q) begin
            first_d = pn_e ? val : VAL_W'(1);
            colon_d = 1'b1;
            pn_d    = 1'b0;
            ns_d    = NUM_WAIT;
            neg_d   = 1'b0;
            acc_d   = '0;
          end else begin
            pn_d = 1'b1;
            if (ns_e != NUM_DONE) begin
              if (is_digit) begin
                // Multiply by ten as two shifts and an add.
                acc_d = (acc_q << 3) + (acc_q << 1) + {{(VAL_W-4){1'b0}}, chr_i[3:0]};
                ns_d  = NUM_DIGITS;
              end else if ((ns_e == NUM_WAIT) && is_ws) begin
                ns_d = NUM_WAIT;
              end else if ((ns_e == NUM_WAIT) &&
                           ((chr_i == CH_PLUS) || (chr_i == CH_MINUS))) begin
                neg_d = (chr_i == CH_MINUS);
                ns_d  = NUM_DIGITS;
              end else begin
                ns_d = NUM_DONE;
              end
            end
          end
        end
      end
    end

    if (cmd_i.finish && phase_q && cp_q) begin
      fin_req = 1'b1;
      fin_pn  = pn_q;
    end

    if (fin_req) begin
      wr_st     = colon_q ? first_q : (fin_pn ? val : VAL_W'(1));
      wr_en_val = fin_pn ? val : '0;
      if (colon_q || !fin_pn) begin
        slice_d = 1'b1;
      end
      if (fc_q < CNT_W'(MAX_DIMS)) begin
        wr_en = 1'b1;
        fc_d  = fc_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
      colon_d = 1'b0;
      pn_d    = 1'b0;
      ns_d    = NUM_WAIT;
      neg_d   = 1'b0;
      acc_d   = '0;
    end

    // The bounds themselves are read from the stores in the output register.
    if (cmd_i.emit_dim) begin
      load   = 1'b1;
      kind_d = KIND_DIM;
      nc_d   = '0;
      didx_d = DIM_IDX_W'(fl_q);
      arr_d  = 1'b0;
      sl_d   = 1'b0;
      cnt_d  = '0;
      err_d  = ERR_NONE;
      lo_d   = 1'b0;
      fl_d   = fl_q + 1'b1;
    end

    if (cmd_i.emit_sum) begin
      load   = 1'b1;
      kind_d = KIND_SUM;
      nc_d   = '0;
      didx_d = '0;
      dst_d  = '0;
      den_d  = '0;
      arr_d  = ok;
      sl_d   = ok && slice_q;
      cnt_d  = ok ? DIM_CNT_W'(fc_q) : '0;
      if (!phase_q) begin
        err_d = ERR_NONE;
      end else if (!cp_q) begin
        err_d = ERR_NO_CLOSE;
      end else if (ovf_q) begin
        err_d = ERR_TOO_MANY;
      end else begin
        err_d = ERR_NONE;
      end
      lo_d    = 1'b1;
      phase_d = 1'b0;
      cp_d    = 1'b0;
      fc_d    = '0;
      colon_d = 1'b0;
      pn_d    = 1'b0;
      ns_d    = NUM_WAIT;
      neg_d   = 1'b0;
      acc_d   = '0;
      first_d = '0;
      slice_d = 1'b0;
      ovf_d   = 1'b0;
      fl_d    = '0;
    end

    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      cp_q        <= 1'b0;
      fc_q        <= '0;
      colon_q     <= 1'b0;
      pn_q        <= 1'b0;
      ns_q        <= NUM_WAIT;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      first_q     <= '0;
      slice_q     <= 1'b0;
      ovf_q       <= 1'b0;
      fl_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cp_q        <= cp_d;
      fc_q        <= fc_d;
      colon_q     <= colon_d;
      pn_q        <= pn_d;
      ns_q        <= ns_d;
      neg_q       <= neg_d;
      acc_q       <= acc_d;
      first_q     <= first_d;
      slice_q     <= slice_d;
      ovf_q       <= ovf_d;
      fl_q        <= fl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_mem[fc_q[IDX_W-1:0]] <= wr_st;
      end_mem[fc_q[IDX_W-1:0]]   <= wr_en_val;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    nc_q   <= nc_d;
    didx_q <= didx_d;
    if (cmd_i.emit_dim) begin
      dst_q <= start_mem[fl_q[IDX_W-1:0]];
      den_q <= end_mem[fl_q[IDX_W-1:0]];
    end else begin
      dst_q <= dst_d;
      den_q <= den_d;
    end
    arr_q  <= arr_d;
    sl_q   <= sl_d;
    cnt_q  <= cnt_d;
    err_q  <= err_d;
    lo_q   <= lo_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign name_char_o = nc_q;
  assign dim_index_o = didx_q;
  assign dim_start_o = dst_q;
  assign dim_end_o   = den_q;
  assign is_array_o  = arr_q;
  assign is_slice_o  = sl_q;
  assign dim_count_o = cnt_q;
  assign error_o     = err_q;
  assign last_out_o  = lo_q;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for the subscript specifier parser core.
`timescale 1ns / 100ps

module tb import asp_pkg::*; ();

  // One expected or observed result of the parser.
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [CHR_W-1:0]     name_char;
    logic [DIM_IDX_W-1:0] dim_index;
    logic [VAL_W-1:0]     dim_start;
    logic [VAL_W-1:0]     dim_end;
    logic                 is_array;
    logic                 is_slice;
    logic [DIM_CNT_W-1:0] dim_count;
    logic [ERR_W-1:0]     error;
    logic                 last_out;
  } spec_result_t;

  typedef logic [CHR_W-1:0] char_q_t[$];

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_CHARS  = 60;
  localparam int IDLE_PCT      = 37;

  // Ports of the block. Every input starts at a known value.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [CHR_W-1:0]      chr_i       = '0;
  logic                  last_i      = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [KIND_W-1:0]     kind_o;
  logic [CHR_W-1:0]      name_char_o;
  logic [DIM_IDX_W-1:0]  dim_index_o;
  logic signed [VAL_W-1:0] dim_start_o;
  logic signed [VAL_W-1:0] dim_end_o;
  logic                  is_array_o;
  logic                  is_slice_o;
  logic [DIM_CNT_W-1:0]  dim_count_o;
  logic [ERR_W-1:0]      error_o;
  logic                  last_out_o;

  array_subscript_spec_parser_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .chr_i       (chr_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .name_char_o (name_char_o),
    .dim_index_o (dim_index_o),
    .dim_start_o (dim_start_o),
    .dim_end_o   (dim_end_o),
    .is_array_o  (is_array_o),
    .is_slice_o  (is_slice_o),
    .dim_count_o (dim_count_o),
    .error_o     (error_o),
    .last_out_o  (last_out_o)
  );

  // Results predicted for accepted characters, oldest first.
  spec_result_t pending_results[$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  chars_sent     = 0;
  bit  tx_idle        = 1'b0;  // sender inserts random gaps
  bit  rx_idle        = 1'b0;  // receiver stalls at random
  int  rx_hold        = 0;     // cycles the receiver still holds off

  // Parser state of the predictor. It mirrors what the block has to track
  // between characters of one specifier.
  bit               in_parens;
  bit               close_held;    // a ')' waits to see if it is the last byte
  int               fld_cnt;
  bit               colon_hit;
  bit               part_used;
  num_state_e       num_st;
  bit               neg;
  logic [VAL_W-1:0] acc;
  logic [VAL_W-1:0] first_val;
  bit               any_slice;
  bit               overflow;
  logic [VAL_W-1:0] start_mem [MAX_DIMS];
  logic [VAL_W-1:0] end_mem   [MAX_DIMS];

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic void clear_part();
    part_used = 1'b0;
    num_st    = NUM_WAIT;
    neg       = 1'b0;
    acc       = '0;
  endfunction

  function automatic void clear_spec();
    in_parens  = 1'b0;
    close_held = 1'b0;
    fld_cnt    = 0;
    colon_hit  = 1'b0;
    first_val  = '0;
    any_slice  = 1'b0;
    overflow   = 1'b0;
    clear_part();
  endfunction

  function automatic logic [VAL_W-1:0] part_value();
    return neg ? (VAL_W'(0) - acc) : acc;
  endfunction

  // Number conversion in the style of atoi: leading whitespace, a sign, then
  // digits; the first other byte freezes the value. Magnitudes wrap.
  function automatic void digit_feed(logic [CHR_W-1:0] c);
    if (num_st == NUM_DONE) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      acc    = acc * 10 + VAL_W'(c - CH_ZERO);
      num_st = NUM_DIGITS;
    end else if (num_st == NUM_WAIT && c >= CH_TAB && c <= CH_CR) begin
      // Leading whitespace leaves the number untouched.
    end else if (num_st == NUM_WAIT && (c == CH_PLUS || c == CH_MINUS)) begin
      neg    = (c == CH_MINUS);
      num_st = NUM_DIGITS;
    end else begin
      num_st = NUM_DONE;
    end
  endfunction

  // A comma or the closing parenthesis ends a field and stores its bounds.
  function automatic void close_field();
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    v = part_value();
    if (colon_hit) begin
      lo        = first_val;
      hi        = part_used ? v : '0;
      any_slice = 1'b1;
    end else if (part_used) begin
      lo = v;
      hi = v;
    end else begin
      // An empty field is the full slice.
      lo        = VAL_W'(1);
      hi        = '0;
      any_slice = 1'b1;
    end
    if (fld_cnt < MAX_DIMS) begin
      start_mem[IDX_W'(fld_cnt)] = lo;
      end_mem[IDX_W'(fld_cnt)]   = hi;
      fld_cnt++;
    end else begin
      overflow = 1'b1;
    end
    colon_hit = 1'b0;
    clear_part();
  endfunction

  function automatic void field_byte(logic [CHR_W-1:0] c);
    if (c == CH_COMMA) begin
      close_field();
    end else if (c == CH_COLON && !colon_hit) begin
      first_val = part_used ? part_value() : VAL_W'(1);
      colon_hit = 1'b1;
      clear_part();
    end else begin
      // Anything else, a second colon included, is part of the field text.
      part_used = 1'b1;
      digit_feed(c);
    end
  endfunction

  // Works out the results caused by one accepted character.
  function automatic void derive_results(logic [CHR_W-1:0] c, logic is_last);
    spec_result_t r;
    if (!in_parens) begin
      if (c == CH_LPAREN) begin
        in_parens = 1'b1;
      end else begin
        r           = '0;
        r.kind      = KIND_NAME;
        r.name_char = c;
        pending_results.push_back(r);
      end
    end else if (c != CH_SPACE) begin
      // A ')' only closes the list when no other non-space byte follows.
      if (close_held) begin
        close_held = 1'b0;
        field_byte(CH_RPAREN);
      end
      if (c == CH_RPAREN) close_held = 1'b1;
      else field_byte(c);
    end

    if (is_last) begin
      spec_result_t sum;
      sum          = '0;
      sum.kind     = KIND_SUM;
      sum.last_out = 1'b1;
      sum.error    = ERR_NONE;
      if (in_parens) begin
        if (!close_held) begin
          sum.error = ERR_NO_CLOSE;
        end else begin
          close_field();
          if (overflow) begin
            sum.error = ERR_TOO_MANY;
          end else begin
            for (int k = 0; k < fld_cnt; k++) begin
              r           = '0;
              r.kind      = KIND_DIM;
              r.dim_index = DIM_IDX_W'(k);
              r.dim_start = start_mem[IDX_W'(k)];
              r.dim_end   = end_mem[IDX_W'(k)];
              pending_results.push_back(r);
            end
            sum.is_array  = 1'b1;
            sum.is_slice  = any_slice;
            sum.dim_count = DIM_CNT_W'(fld_cnt);
          end
        end
      end
      pending_results.push_back(sum);
      clear_spec();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Clock, watchdog, receiver and result checking
  // ---------------------------------------------------------------------

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("array_subscript_spec_parser_core: mismatch");
      $finish;
    end
  end

  // The receiver decides on ready at every falling edge. A hold-off set by a
  // test is counted down here so the sender keeps running in parallel.
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else if (rx_idle) begin
        out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic void check_field(string fname, logic [VAL_W-1:0] want,
                                      logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, $signed(want), $signed(got));
      mismatch_count++;
    end
  endfunction

  // Every output transfer is matched against the oldest prediction.
  always @(posedge clk_i) begin
    spec_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing predicted: kind %0d", kind_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind",      VAL_W'(want.kind),      VAL_W'(kind_o));
        check_field("name_char", VAL_W'(want.name_char), VAL_W'(name_char_o));
        check_field("dim_index", VAL_W'(want.dim_index), VAL_W'(dim_index_o));
        check_field("dim_start", want.dim_start,         dim_start_o);
        check_field("dim_end",   want.dim_end,           dim_end_o);
        check_field("is_array",  VAL_W'(want.is_array),  VAL_W'(is_array_o));
        check_field("is_slice",  VAL_W'(want.is_slice),  VAL_W'(is_slice_o));
        check_field("dim_count", VAL_W'(want.dim_count), VAL_W'(dim_count_o));
        check_field("error",     VAL_W'(want.error),     VAL_W'(error_o));
        check_field("last_out",  VAL_W'(want.last_out),  VAL_W'(last_out_o));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // Offers one character and returns at the edge of its transfer. Gaps are
  // inserted before valid rises; once raised, valid and payload stay put.
  task automatic send_char(input logic [CHR_W-1:0] c, input logic is_last);
    @(negedge clk_i);
    while (tx_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    chr_i      <= c;
    last_i     <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    derive_results(c, is_last);
    chars_sent++;
  endtask

  // Lowers valid before any wait that is not a transfer of a new character.
  task automatic hold_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_spec(input char_q_t s);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic wait_all_results();
    hold_input();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic char_q_t text_bytes(string t);
    char_q_t q;
    q = {};
    for (int i = 0; i < t.len(); i++) q.push_back(t[i]);
    return q;
  endfunction

  // ---------------------------------------------------------------------
  // Random specifiers
  // ---------------------------------------------------------------------

  function automatic logic [CHR_W-1:0] name_byte();
    logic [CHR_W-1:0] b;
    if ($urandom_range(99) < 50) return CHR_W'($urandom_range(8'h61, 8'h7A));
    b = CHR_W'($urandom_range(255));
    return (b == CH_LPAREN) ? 8'h41 : b;
  endfunction

  function automatic void maybe_space(ref char_q_t s);
    if ($urandom_range(99) < 8) s.push_back(CH_SPACE);
  endfunction

  // Signed decimal number with optional leading whitespace and tail text.
  function automatic void add_number(ref char_q_t s);
    int ndig;
    if ($urandom_range(99) < 10) s.push_back(CHR_W'($urandom_range(CH_TAB, CH_CR)));
    maybe_space(s);
    if ($urandom_range(99) < 30) s.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
    ndig = ($urandom_range(99) < 8) ? $urandom_range(10, 12) : $urandom_range(1, 3);
    repeat (ndig) s.push_back(CHR_W'(CH_ZERO + $urandom_range(9)));
    if ($urandom_range(99) < 10) s.push_back(CHR_W'($urandom_range(255)));
    maybe_space(s);
  endfunction

  function automatic void add_field(ref char_q_t s);
    int r;
    r = $urandom_range(99);
    if (r < 12) begin
      maybe_space(s);
    end else if (r < 55) begin
      add_number(s);
    end else if (r < 85) begin
      if ($urandom_range(99) < 70) add_number(s);
      s.push_back(CH_COLON);
      if ($urandom_range(99) < 70) add_number(s);
    end else begin
      repeat ($urandom_range(1, 4)) s.push_back(CHR_W'($urandom_range(255)));
    end
  endfunction

  // Mostly well-formed specifiers with random content; the rest lack the
  // parenthesis, lose the closing one, carry junk after it, or are noise.
  function automatic char_q_t random_spec();
    char_q_t s;
    int shape;
    int nfld;
    int r;
    s = {};
    repeat ($urandom_range(0, 3)) s.push_back(name_byte());
    shape = $urandom_range(99);
    if (shape < 8) begin
      s.push_back(name_byte());
      return s;
    end
    s.push_back(CH_LPAREN);
    if (shape < 12) begin
      repeat ($urandom_range(0, 5)) s.push_back(CHR_W'($urandom_range(255)));
      return s;
    end
    r    = $urandom_range(99);
    nfld = (r < 70) ? $urandom_range(1, 3) :
           (r < 85) ? $urandom_range(4, 6) : $urandom_range(MAX_DIMS, MAX_DIMS + 2);
    for (int i = 0; i < nfld; i++) begin
      if (i > 0) s.push_back(CH_COMMA);
      add_field(s);
    end
    r = $urandom_range(99);
    if (r < 82) begin
      s.push_back(CH_RPAREN);
      maybe_space(s);
    end else if (r >= 91) begin
      s.push_back(CH_RPAREN);
      s.push_back(CHR_W'($urandom_range(255)));
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Name bytes at both ends of the byte range, ending without a parenthesis.
  task automatic test_name_only();
    char_q_t s;
    s = '{8'hFF, 8'h00};
    send_spec(s);
  endtask

  // Nothing after '(' and a final byte that is not ')'. The ')' in the middle
  // and the NUL are plain field text.
  task automatic test_missing_close();
    char_q_t s;
    send_spec(text_bytes("("));
    s = text_bytes("(1)");
    s.push_back(8'h00);
    send_spec(s);
  endtask

  task automatic test_empty_parens();
    send_spec(text_bytes("()"));
  endtask

  // Dropped space, open-ended slices, signs, a leading tab, junk and a second
  // colon ending a number, and empty fields.
  task automatic test_slice_forms();
    send_spec(text_bytes("( -2:,:+3,\t7z:9:5,,)"));
  endtask

  // One field beyond the limit.
  task automatic test_too_many_dims();
    send_spec(text_bytes("(,,,,,,,)"));
  endtask

  // The receiver stops for a long stretch while characters keep coming, so
  // the output register fills and the input is stalled.
  task automatic test_output_stall();
    rx_hold = 80;
    send_spec(text_bytes("stalled_name_field(1:2,3)"));
  endtask

  // The sender waits for every outstanding result before going on.
  task automatic test_drain_pause();
    send_spec(random_spec());
    wait_all_results();
    send_spec(random_spec());
  endtask

  // Back-to-back transfers on both channels; the bench adds no gaps or stalls.
  task automatic test_steady_stream();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (4) send_spec(random_spec());
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_specs();
    int first;
    first = chars_sent;
    while (chars_sent - first < RANDOM_CHARS) send_spec(random_spec());
  endtask

  initial begin
    clear_spec();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_name_only();
    test_missing_close();
    test_empty_parens();
    test_slice_forms();
    test_too_many_dims();
    test_output_stall();
    test_drain_pause();
    test_steady_stream();
    test_random_specs();

    // Let the flush of the last specifier finish before judging.
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("array_subscript_spec_parser_core: match");
    end else begin
      $display("array_subscript_spec_parser_core: mismatch");
    end
    $finish;
  end

endmodule

@@ array_subscript_spec_parser_core.f @@
hw/rtl/asp_pkg.sv
hw/rtl/asp_ctrl.sv
hw/rtl/asp_datapath.sv
hw/rtl/array_subscript_spec_parser_core.sv
bench/tb.sv
